// ----- rtl/core/bfs_pkg.sv -----
// shared types, constants and command and status structs of the boids flocking step core
package bfs_pkg;

    localparam int MAX_BOIDS   = 256;
    localparam int IDX_W       = $clog2(MAX_BOIDS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int FRAC_BITS   = 8;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int POS_W       = 20;
    localparam int VEL_W       = 16;
    localparam int TOTAL_W     = 8;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 88;
    localparam int ADDR_W      = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic CFG_BOID_COUNT_IDX = 1'b0;

    localparam int SEP_RANGE   = 20;
    localparam int VIS_RANGE   = 75;
    localparam int SPEED_CAP   = 15;
    localparam int MARGIN      = 200;
    localparam int WIN_W       = 640;
    localparam int WIN_H       = 480;
    localparam int SEP_DIV     = 20;
    localparam int ALIGN_DIV   = 20;
    localparam int COH_DIV     = 200;
    localparam int STEP_NUM    = 167;
    localparam int STEP_DEN    = 1000;

    localparam int CAP         = SPEED_CAP * ONE;
    localparam int SEP2        = (SEP_RANGE * ONE) * (SEP_RANGE * ONE);
    localparam int VIS2        = (VIS_RANGE * ONE) * (VIS_RANGE * ONE);
    localparam int CAP2        = CAP * CAP;

    localparam int DX_W        = POS_W + 1;
    localparam int DV_W        = VEL_W + 1;
    localparam int D2_W        = 2 * DX_W;
    localparam int SEP_W       = 22;
    localparam int COH_W       = 24;
    localparam int ALN_W       = 25;
    localparam int NV_W        = 20;
    localparam int NUM_W       = 33;
    localparam int DEN_W       = 21;
    localparam int MAG_W       = 34;
    localparam int Q_W         = 20;
    localparam int SQ_IN_W     = 42;
    localparam int SQ_OUT_W    = SQ_IN_W / 2;

    typedef enum logic [3:0] {
        DIV_SEPX, DIV_SEPY, DIV_ALX, DIV_ALY, DIV_COX, DIV_COY,
        DIV_LIMX, DIV_LIMY, DIV_STPX, DIV_STPY
    } div_op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_RDSELF, ST_TAKE, ST_SCAN, ST_DRAIN, ST_DSTART,
        ST_DWAIT, ST_SQ, ST_CMP, ST_SQRT, ST_TURN, ST_WB
    } state_t;

    typedef struct packed {
        logic             capture;
        logic             wr_load;
        logic             rd_self;
        logic             rd_scan;
        logic [IDX_W-1:0] scan_idx;
        logic             take;
        logic             div_start;
        div_op_t          div_op;
        logic             sq;
        logic             sqrt_start;
        logic             turn;
        logic             wb;
    } bfs_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic over_cap;
        logic n_zero;
        logic out_busy;
    } bfs_sts_t;

endpackage

// ----- rtl/core/bfs_div.sv -----
// iterative rounding divider, two quotient bits per cycle
module bfs_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [bfs_pkg::NUM_W-1:0]   num,
    input  logic        [bfs_pkg::DEN_W-1:0]   den,
    output logic                               done,
    output logic signed [bfs_pkg::Q_W-1:0]     quo
);

    localparam int STEPS = bfs_pkg::MAG_W / 2;
    localparam int SC_W  = $clog2(STEPS);

    logic [bfs_pkg::MAG_W-1:0] a_reg, a_next;
    logic [bfs_pkg::DEN_W:0]   r_reg, r_next;
    logic [bfs_pkg::DEN_W-1:0] den_reg;
    logic                      neg_reg;
    logic                      run_reg;
    logic                      done_reg;
    logic [SC_W-1:0]           cnt_reg;
    logic [bfs_pkg::NUM_W-1:0] abs_num;
    logic [bfs_pkg::MAG_W-1:0] mag;
    logic [bfs_pkg::Q_W-1:0]   qm;

    always_comb begin
        abs_num = num[bfs_pkg::NUM_W-1] ? bfs_pkg::NUM_W'(-num) : bfs_pkg::NUM_W'(num);
        mag     = bfs_pkg::MAG_W'(abs_num) + bfs_pkg::MAG_W'(den >> 1);
    end

    always_comb begin
        r_next = r_reg;
        a_next = a_reg;
        for (int k = 0; k < 2; k++) begin
            r_next = {r_next[bfs_pkg::DEN_W-1:0], a_next[bfs_pkg::MAG_W-1]};
            a_next = {a_next[bfs_pkg::MAG_W-2:0], 1'b0};
            if (r_next >= {1'b0, den_reg}) begin
                r_next    = r_next - {1'b0, den_reg};
                a_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SC_W'(STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= mag;
            r_reg   <= '0;
            den_reg <= den;
            neg_reg <= num[bfs_pkg::NUM_W-1];
        end else if (run_reg) begin
            a_reg <= a_next;
            r_reg <= r_next;
        end
    end

    assign qm   = a_reg[bfs_pkg::Q_W-1:0];
    assign quo  = neg_reg ? $signed(~qm + 1'b1) : $signed(qm);
    assign done = done_reg;

endmodule

// ----- rtl/core/bfs_sqrt.sv -----
// iterative integer square root, one result bit per cycle
module bfs_sqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [bfs_pkg::SQ_IN_W-1:0]    val,
    output logic                           done,
    output logic [bfs_pkg::SQ_OUT_W-1:0]   root
);

    logic [bfs_pkg::SQ_IN_W-1:0] n_reg, r_reg, b_reg, t;
    logic                        run_reg;
    logic                        done_reg;

    assign t = r_reg + b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
            end else if (run_reg && b_reg[0]) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg <= val;
            r_reg <= '0;
            b_reg <= bfs_pkg::SQ_IN_W'(1) << (bfs_pkg::SQ_IN_W - 2);
        end else if (run_reg) begin
            if (n_reg >= t) begin
                n_reg <= n_reg - t;
                r_reg <= (r_reg >> 1) + b_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    assign root = r_reg[bfs_pkg::SQ_OUT_W-1:0];
    assign done = done_reg;

endmodule

// ----- rtl/core/bfs_dp.sv -----
// datapath: boid store, neighbour pipeline, accumulators, divider, square root, output register
module bfs_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bfs_pkg::bfs_cmd_t                   cmd,
    output bfs_pkg::bfs_sts_t                   sts,
    input  logic [bfs_pkg::IN_DATA_W-1:0]       in_data,
    output logic [bfs_pkg::OUT_DATA_W-1:0]      out_data,
    output logic                                out_valid,
    input  logic                                out_ready
);

    localparam logic signed [bfs_pkg::D2_W-1:0] SEP2_C = bfs_pkg::D2_W'(bfs_pkg::SEP2);
    localparam logic signed [bfs_pkg::D2_W-1:0] VIS2_C = bfs_pkg::D2_W'(bfs_pkg::VIS2);
    localparam logic signed [bfs_pkg::D2_W-1:0] CAP2_C = bfs_pkg::D2_W'(bfs_pkg::CAP2);
    localparam logic signed [bfs_pkg::NUM_W-1:0] CAP_C = bfs_pkg::NUM_W'(bfs_pkg::CAP);
    localparam logic signed [bfs_pkg::NUM_W-1:0] STEP_C = bfs_pkg::NUM_W'(bfs_pkg::STEP_NUM);
    localparam logic signed [bfs_pkg::POS_W-1:0] TURN_LO =
        bfs_pkg::POS_W'(bfs_pkg::MARGIN * bfs_pkg::ONE);
    localparam logic signed [bfs_pkg::POS_W-1:0] TURN_XHI =
        bfs_pkg::POS_W'((bfs_pkg::WIN_W - bfs_pkg::MARGIN) * bfs_pkg::ONE);
    localparam logic signed [bfs_pkg::POS_W-1:0] TURN_YHI =
        bfs_pkg::POS_W'((bfs_pkg::WIN_H - bfs_pkg::MARGIN) * bfs_pkg::ONE);
    localparam logic signed [bfs_pkg::NV_W:0] ONE_C = (bfs_pkg::NV_W + 1)'(bfs_pkg::ONE);

    function automatic logic signed [bfs_pkg::VEL_W-1:0] sat_v(
        input logic signed [bfs_pkg::NV_W:0] v);
        logic signed [bfs_pkg::NV_W:0] hi;
        logic signed [bfs_pkg::NV_W:0] lo;
        hi = (bfs_pkg::NV_W + 1)'((1 << (bfs_pkg::VEL_W - 1)) - 1);
        lo = -hi - (bfs_pkg::NV_W + 1)'(1);
        if (v > hi) return hi[bfs_pkg::VEL_W-1:0];
        if (v < lo) return lo[bfs_pkg::VEL_W-1:0];
        return v[bfs_pkg::VEL_W-1:0];
    endfunction

    function automatic logic signed [bfs_pkg::POS_W-1:0] sat_p(
        input logic signed [bfs_pkg::POS_W:0] v);
        logic signed [bfs_pkg::POS_W:0] hi;
        logic signed [bfs_pkg::POS_W:0] lo;
        hi = (bfs_pkg::POS_W + 1)'((1 << (bfs_pkg::POS_W - 1)) - 1);
        lo = -hi - (bfs_pkg::POS_W + 1)'(1);
        if (v > hi) return hi[bfs_pkg::POS_W-1:0];
        if (v < lo) return lo[bfs_pkg::POS_W-1:0];
        return v[bfs_pkg::POS_W-1:0];
    endfunction

    logic        [bfs_pkg::IDX_W-1:0] idx_reg;
    logic signed [bfs_pkg::POS_W-1:0] ld_px_reg, ld_py_reg;
    logic signed [bfs_pkg::VEL_W-1:0] ld_vx_reg, ld_vy_reg;

    logic signed [bfs_pkg::POS_W-1:0] px_mem [bfs_pkg::MAX_BOIDS];
    logic signed [bfs_pkg::POS_W-1:0] py_mem [bfs_pkg::MAX_BOIDS];
    logic signed [bfs_pkg::VEL_W-1:0] vx_mem [bfs_pkg::MAX_BOIDS];
    logic signed [bfs_pkg::VEL_W-1:0] vy_mem [bfs_pkg::MAX_BOIDS];

    logic                             wr_en;
    logic        [bfs_pkg::IDX_W-1:0] rd_addr;
    logic signed [bfs_pkg::POS_W-1:0] wpx, wpy;
    logic signed [bfs_pkg::VEL_W-1:0] wvx, wvy;
    logic signed [bfs_pkg::POS_W-1:0] rd_px_reg, rd_py_reg;
    logic signed [bfs_pkg::VEL_W-1:0] rd_vx_reg, rd_vy_reg;

    logic signed [bfs_pkg::POS_W-1:0] spx_reg, spy_reg;
    logic signed [bfs_pkg::VEL_W-1:0] svx_reg, svy_reg;

    logic                             rv_reg, p1v_reg, p2v_reg;
    logic signed [bfs_pkg::DX_W-1:0]  dx_reg, dy_reg, dx2_reg, dy2_reg;
    logic signed [bfs_pkg::DV_W-1:0]  dvx_reg, dvy_reg, dvx2_reg, dvy2_reg;
    logic signed [bfs_pkg::D2_W-1:0]  sqx_reg, sqy_reg, d2;

    logic signed [bfs_pkg::SEP_W-1:0] sepx_reg, sepy_reg;
    logic signed [bfs_pkg::COH_W-1:0] cox_reg, coy_reg;
    logic signed [bfs_pkg::ALN_W-1:0] alx_reg, aly_reg;
    logic        [bfs_pkg::CNT_W-1:0] n_reg;

    logic signed [bfs_pkg::NV_W-1:0]  nx_reg, ny_reg;
    logic signed [bfs_pkg::D2_W-1:0]  mx_reg, my_reg, m2;
    logic signed [bfs_pkg::POS_W-1:0] npx_reg, npy_reg;
    logic signed [bfs_pkg::NV_W:0]    tx, ty;

    bfs_pkg::div_op_t                 dop_reg;
    logic signed [bfs_pkg::NUM_W-1:0] div_num;
    logic        [bfs_pkg::DEN_W-1:0] div_den;
    logic                             div_done;
    logic signed [bfs_pkg::Q_W-1:0]   div_q;
    logic                             sqrt_done;
    logic        [bfs_pkg::SQ_OUT_W-1:0] sq_root;

    logic                              out_valid_reg;
    logic [bfs_pkg::OUT_DATA_W-1:0]    out_data_reg;
    logic [bfs_pkg::TOTAL_W-1:0]       n_sat;

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            idx_reg   <= in_data[7:0];
            ld_px_reg <= in_data[27:8];
            ld_py_reg <= in_data[47:28];
            ld_vx_reg <= in_data[63:48];
            ld_vy_reg <= in_data[79:64];
        end
    end

    // boid store
    always_comb begin
        wr_en   = cmd.wr_load | cmd.wb;
        rd_addr = cmd.rd_self ? idx_reg : cmd.scan_idx;
        if (cmd.wb) begin
            wpx = npx_reg;
            wpy = npy_reg;
            wvx = bfs_pkg::VEL_W'(nx_reg);
            wvy = bfs_pkg::VEL_W'(ny_reg);
        end else begin
            wpx = ld_px_reg;
            wpy = ld_py_reg;
            wvx = ld_vx_reg;
            wvy = ld_vy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            px_mem[idx_reg] <= wpx;
            py_mem[idx_reg] <= wpy;
            vx_mem[idx_reg] <= wvx;
            vy_mem[idx_reg] <= wvy;
        end
        rd_px_reg <= px_mem[rd_addr];
        rd_py_reg <= py_mem[rd_addr];
        rd_vx_reg <= vx_mem[rd_addr];
        rd_vy_reg <= vy_mem[rd_addr];
    end

    // neighbour pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg  <= 1'b0;
            p1v_reg <= 1'b0;
            p2v_reg <= 1'b0;
        end else begin
            rv_reg  <= cmd.rd_scan && (cmd.scan_idx != idx_reg);
            p1v_reg <= rv_reg;
            p2v_reg <= p1v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg   <= bfs_pkg::DX_W'(spx_reg) - bfs_pkg::DX_W'(rd_px_reg);
        dy_reg   <= bfs_pkg::DX_W'(spy_reg) - bfs_pkg::DX_W'(rd_py_reg);
        dvx_reg  <= bfs_pkg::DV_W'(rd_vx_reg) - bfs_pkg::DV_W'(svx_reg);
        dvy_reg  <= bfs_pkg::DV_W'(rd_vy_reg) - bfs_pkg::DV_W'(svy_reg);
        sqx_reg  <= dx_reg * dx_reg;
        sqy_reg  <= dy_reg * dy_reg;
        dx2_reg  <= dx_reg;
        dy2_reg  <= dy_reg;
        dvx2_reg <= dvx_reg;
        dvy2_reg <= dvy_reg;
    end

    assign d2 = sqx_reg + sqy_reg;

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            spx_reg  <= rd_px_reg;
            spy_reg  <= rd_py_reg;
            svx_reg  <= rd_vx_reg;
            svy_reg  <= rd_vy_reg;
            sepx_reg <= '0;
            sepy_reg <= '0;
            cox_reg  <= '0;
            coy_reg  <= '0;
            alx_reg  <= '0;
            aly_reg  <= '0;
            n_reg    <= '0;
        end else if (p2v_reg) begin
            if (d2 < SEP2_C) begin
                sepx_reg <= sepx_reg + bfs_pkg::SEP_W'(dx2_reg);
                sepy_reg <= sepy_reg + bfs_pkg::SEP_W'(dy2_reg);
            end
            if (d2 < VIS2_C) begin
                cox_reg <= cox_reg - bfs_pkg::COH_W'(dx2_reg);
                coy_reg <= coy_reg - bfs_pkg::COH_W'(dy2_reg);
                alx_reg <= alx_reg + bfs_pkg::ALN_W'(dvx2_reg);
                aly_reg <= aly_reg + bfs_pkg::ALN_W'(dvy2_reg);
                n_reg   <= n_reg + 1'b1;
            end
        end
    end

    // divider operands
    always_comb begin
        unique case (cmd.div_op)
            bfs_pkg::DIV_SEPX: begin
                div_num = bfs_pkg::NUM_W'(sepx_reg);
                div_den = bfs_pkg::DEN_W'(bfs_pkg::SEP_DIV);
            end
            bfs_pkg::DIV_SEPY: begin
                div_num = bfs_pkg::NUM_W'(sepy_reg);
                div_den = bfs_pkg::DEN_W'(bfs_pkg::SEP_DIV);
            end
            bfs_pkg::DIV_ALX: begin
                div_num = bfs_pkg::NUM_W'(alx_reg);
                div_den = bfs_pkg::DEN_W'(n_reg) * bfs_pkg::DEN_W'(bfs_pkg::ALIGN_DIV);
            end
            bfs_pkg::DIV_ALY: begin
                div_num = bfs_pkg::NUM_W'(aly_reg);
                div_den = bfs_pkg::DEN_W'(n_reg) * bfs_pkg::DEN_W'(bfs_pkg::ALIGN_DIV);
            end
            bfs_pkg::DIV_COX: begin
                div_num = bfs_pkg::NUM_W'(cox_reg);
                div_den = bfs_pkg::DEN_W'(n_reg) * bfs_pkg::DEN_W'(bfs_pkg::COH_DIV);
            end
            bfs_pkg::DIV_COY: begin
                div_num = bfs_pkg::NUM_W'(coy_reg);
                div_den = bfs_pkg::DEN_W'(n_reg) * bfs_pkg::DEN_W'(bfs_pkg::COH_DIV);
            end
            bfs_pkg::DIV_LIMX: begin
                div_num = bfs_pkg::NUM_W'(nx_reg) * CAP_C;
                div_den = bfs_pkg::DEN_W'(sq_root);
            end
            bfs_pkg::DIV_LIMY: begin
                div_num = bfs_pkg::NUM_W'(ny_reg) * CAP_C;
                div_den = bfs_pkg::DEN_W'(sq_root);
            end
            bfs_pkg::DIV_STPX: begin
                div_num = bfs_pkg::NUM_W'(nx_reg) * STEP_C;
                div_den = bfs_pkg::DEN_W'(bfs_pkg::STEP_DEN);
            end
            bfs_pkg::DIV_STPY: begin
                div_num = bfs_pkg::NUM_W'(ny_reg) * STEP_C;
                div_den = bfs_pkg::DEN_W'(bfs_pkg::STEP_DEN);
            end
            default: begin
                div_num = '0;
                div_den = bfs_pkg::DEN_W'(1);
            end
        endcase
    end

    bfs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_q)
    );

    assign m2 = mx_reg + my_reg;

    bfs_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .val     (bfs_pkg::SQ_IN_W'(m2)),
        .done    (sqrt_done),
        .root    (sq_root)
    );

    // margin turn terms from the old position
    always_comb begin
        if (spx_reg < TURN_LO) tx = ONE_C;
        else if (spx_reg > TURN_XHI) tx = -ONE_C;
        else tx = '0;
        if (spy_reg < TURN_LO) ty = ONE_C;
        else if (spy_reg > TURN_YHI) ty = -ONE_C;
        else ty = '0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) dop_reg <= cmd.div_op;
        if (cmd.sq) begin
            mx_reg <= nx_reg * nx_reg;
            my_reg <= ny_reg * ny_reg;
        end
        if (cmd.turn) begin
            nx_reg <= bfs_pkg::NV_W'(sat_v((bfs_pkg::NV_W + 1)'(nx_reg) + tx));
            ny_reg <= bfs_pkg::NV_W'(sat_v((bfs_pkg::NV_W + 1)'(ny_reg) + ty));
        end else if (div_done) begin
            unique case (dop_reg)
                bfs_pkg::DIV_SEPX: nx_reg <= bfs_pkg::NV_W'(svx_reg) + div_q;
                bfs_pkg::DIV_SEPY: ny_reg <= bfs_pkg::NV_W'(svy_reg) + div_q;
                bfs_pkg::DIV_ALX, bfs_pkg::DIV_COX: nx_reg <= nx_reg + div_q;
                bfs_pkg::DIV_ALY, bfs_pkg::DIV_COY: ny_reg <= ny_reg + div_q;
                bfs_pkg::DIV_LIMX: nx_reg <= div_q;
                bfs_pkg::DIV_LIMY: ny_reg <= div_q;
                bfs_pkg::DIV_STPX:
                    npx_reg <= sat_p((bfs_pkg::POS_W + 1)'(spx_reg)
                                     + (bfs_pkg::POS_W + 1)'(div_q));
                bfs_pkg::DIV_STPY:
                    npy_reg <= sat_p((bfs_pkg::POS_W + 1)'(spy_reg)
                                     + (bfs_pkg::POS_W + 1)'(div_q));
                default: ;
            endcase
        end
    end

    // output register
    assign n_sat = (n_reg > bfs_pkg::CNT_W'((1 << bfs_pkg::TOTAL_W) - 1))
                   ? '1 : n_reg[bfs_pkg::TOTAL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.wb) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wb) begin
            out_data_reg <= {n_sat, bfs_pkg::VEL_W'(ny_reg), bfs_pkg::VEL_W'(nx_reg),
                             npy_reg, npx_reg, idx_reg};
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign sts.div_done  = div_done;
    assign sts.sqrt_done = sqrt_done;
    assign sts.over_cap  = m2 > CAP2_C;
    assign sts.n_zero    = (n_reg == '0);
    assign sts.out_busy  = out_valid_reg & ~out_ready;

endmodule

// ----- rtl/core/bfs_ctrl.sv -----
// controller state machine sequencing load, neighbour scan, divisions, square root and write-back
module bfs_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic                          in_mode,
    output logic                          in_ready,
    input  logic [bfs_pkg::CNT_W-1:0]     active,
    input  bfs_pkg::bfs_sts_t             sts,
    output bfs_pkg::bfs_cmd_t             cmd
);

    localparam int DRAIN_CYC = 3;

    bfs_pkg::state_t             state_reg, state_next;
    bfs_pkg::div_op_t            op_reg, op_next;
    logic [bfs_pkg::CNT_W-1:0]   j_reg, j_next;
    logic [1:0]                  drain_reg, drain_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfs_pkg::ST_IDLE;
            op_reg    <= bfs_pkg::DIV_SEPX;
            j_reg     <= '0;
            drain_reg <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            j_reg     <= j_next;
            drain_reg <= drain_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        j_next       = j_reg;
        drain_next   = drain_reg;
        cmd          = '0;
        cmd.div_op   = op_reg;
        cmd.scan_idx = j_reg[bfs_pkg::IDX_W-1:0];
        in_ready     = 1'b0;
        unique case (state_reg)
            bfs_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = in_mode ? bfs_pkg::ST_RDSELF : bfs_pkg::ST_LOAD;
                end
            end
            bfs_pkg::ST_LOAD: begin
                cmd.wr_load = 1'b1;
                state_next  = bfs_pkg::ST_IDLE;
            end
            bfs_pkg::ST_RDSELF: begin
                cmd.rd_self = 1'b1;
                state_next  = bfs_pkg::ST_TAKE;
            end
            bfs_pkg::ST_TAKE: begin
                cmd.take   = 1'b1;
                j_next     = '0;
                state_next = bfs_pkg::ST_SCAN;
            end
            bfs_pkg::ST_SCAN: begin
                if (j_reg == active) begin
                    drain_next = '0;
                    state_next = bfs_pkg::ST_DRAIN;
                end else begin
                    cmd.rd_scan = 1'b1;
                    j_next      = j_reg + 1'b1;
                end
            end
            bfs_pkg::ST_DRAIN: begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'(DRAIN_CYC - 1)) begin
                    op_next    = bfs_pkg::DIV_SEPX;
                    state_next = bfs_pkg::ST_DSTART;
                end
            end
            bfs_pkg::ST_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = bfs_pkg::ST_DWAIT;
            end
            bfs_pkg::ST_DWAIT: begin
                if (sts.div_done) begin
                    state_next = bfs_pkg::ST_DSTART;
                    unique case (op_reg)
                        bfs_pkg::DIV_SEPX: op_next = bfs_pkg::DIV_SEPY;
                        bfs_pkg::DIV_SEPY: begin
                            if (sts.n_zero) state_next = bfs_pkg::ST_SQ;
                            else op_next = bfs_pkg::DIV_ALX;
                        end
                        bfs_pkg::DIV_ALX:  op_next = bfs_pkg::DIV_ALY;
                        bfs_pkg::DIV_ALY:  op_next = bfs_pkg::DIV_COX;
                        bfs_pkg::DIV_COX:  op_next = bfs_pkg::DIV_COY;
                        bfs_pkg::DIV_COY:  state_next = bfs_pkg::ST_SQ;
                        bfs_pkg::DIV_LIMX: op_next = bfs_pkg::DIV_LIMY;
                        bfs_pkg::DIV_LIMY: state_next = bfs_pkg::ST_TURN;
                        bfs_pkg::DIV_STPX: op_next = bfs_pkg::DIV_STPY;
                        bfs_pkg::DIV_STPY: state_next = bfs_pkg::ST_WB;
                        default:           state_next = bfs_pkg::ST_IDLE;
                    endcase
                end
            end
            bfs_pkg::ST_SQ: begin
                cmd.sq     = 1'b1;
                state_next = bfs_pkg::ST_CMP;
            end
            bfs_pkg::ST_CMP: begin
                if (sts.over_cap) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = bfs_pkg::ST_SQRT;
                end else begin
                    state_next = bfs_pkg::ST_TURN;
                end
            end
            bfs_pkg::ST_SQRT: begin
                if (sts.sqrt_done) begin
                    op_next    = bfs_pkg::DIV_LIMX;
                    state_next = bfs_pkg::ST_DSTART;
                end
            end
            bfs_pkg::ST_TURN: begin
                cmd.turn   = 1'b1;
                op_next    = bfs_pkg::DIV_STPX;
                state_next = bfs_pkg::ST_DSTART;
            end
            bfs_pkg::ST_WB: begin
                if (!sts.out_busy) begin
                    cmd.wb     = 1'b1;
                    state_next = bfs_pkg::ST_IDLE;
                end
            end
            default: state_next = bfs_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/boids_flocking_step_core.sv -----
// top level of the boids flocking step core
// Usage:
//   s_ channel carries one item per handshake: tuser selects load (0) or update (1),
//   tdata holds the boid index and the position and velocity to load.
//   A load writes one store entry and gives no result.
//   An update reads its boid, walks boids 0 .. boid_count-1 through a 4-stage
//   distance pipeline (one boid per cycle), then runs up to ten rounding divisions
//   on a shared 2-bit-per-cycle divider and, when the speed is over the cap, an
//   integer square root; boid_count is capped at 256.
//   m_ channel delivers one result per update from an output register; the next
//   item is accepted while a result waits there, but a finished update holds
//   its write-back until that register is free when the receiver stalls.
//   boid_count is written over the APB port at address 0; the user must do this only
//   while the core is idle, which the core does not enforce.
//   Reset clears the controller, the output valid and sets boid_count to 1; the
//   store is undefined until loaded, and no clearing pass is run.
module boids_flocking_step_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // boid_index, load_pos_x, load_pos_y, load_vel_x, load_vel_y
    input  logic [bfs_pkg::IN_DATA_W-1:0]       s_tdata,
    // mode
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // updated_index, new_pos_x, new_pos_y, new_vel_x, new_vel_y, neighbour_total
    output logic [bfs_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bfs_pkg::ADDR_W-1:0]          paddr,
    input  logic [bfs_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bfs_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic [bfs_pkg::CNT_W-1:0] boid_count_reg;
    logic [bfs_pkg::CNT_W-1:0] active;
    logic                      reg_sel;
    bfs_pkg::bfs_cmd_t         cmd;
    bfs_pkg::bfs_sts_t         sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == bfs_pkg::CFG_BOID_COUNT_IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boid_count_reg <= bfs_pkg::CNT_W'(1);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            boid_count_reg <= pwdata[bfs_pkg::CNT_W-1:0];
        end
    end

    assign prdata = reg_sel ? bfs_pkg::APB_DATA_W'(boid_count_reg) : '0;
    assign active = (boid_count_reg > bfs_pkg::CNT_W'(bfs_pkg::MAX_BOIDS))
                    ? bfs_pkg::CNT_W'(bfs_pkg::MAX_BOIDS) : boid_count_reg;

    bfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_ready (s_tready),
        .active   (active),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfs_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .out_data  (m_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");
    a_wb_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wb |-> !sts.out_busy)
        else $error("write-back over an untaken result");
    a_wb_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wb |=> m_tvalid)
        else $error("result not presented after write-back");
`endif

endmodule
